// File: rtl/core/pce_pkg.sv
`default_nettype none
package pce_pkg;

  // width of a step id on the ports
  localparam int unsigned ID_W = 7;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_IMPLIED  = 3'd1,
    ST_CONFLICT = 3'd2,
    ST_BOUNDARY = 3'd3,
    ST_INVALID  = 3'd4
  } status_t;

  typedef enum logic {
    KIND_ADD   = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] first_step;
    logic [ID_W-1:0] second_step;
  } in_word_t;

  typedef struct packed {
    status_t status;
    logic    ordered_before;
    logic    may_precede;
    logic    may_follow;
    logic    may_overlap;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_CAP_B,
    S_CHECK,
    S_WALK,
    S_WALK_END,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    RD_FIRST,
    RD_SECOND,
    RD_WALK
  } rd_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap_a;
    logic    cap_b;
    logic    res_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic add_go;
    logic walk_last;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/core/pce_ram.sv
`default_nettype none
module pce_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: rtl/core/pce_ctrl.sv
`default_nettype none
module pce_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire pce_pkg::sts_t sts,
  output pce_pkg::cmd_t      cmd
);
  import pce_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.rd_sel    = RD_FIRST;
    state_nxt     = state_r;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD_A;
        end
      end
      S_RD_A: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_FIRST;
        state_nxt  = S_RD_B;
      end
      S_RD_B: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SECOND;
        cmd.cap_a  = 1'b1;
        state_nxt  = S_CAP_B;
      end
      S_CAP_B: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = sts.add_go ? S_WALK : S_OUT;
      end
      S_WALK: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_WALK;
        if (sts.walk_last) begin
          state_nxt = S_WALK_END;
        end
      end
      S_WALK_END: begin
        // last row write retires here
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: rtl/core/pce_dp.sv
`default_nettype none
module pce_dp #(
  parameter int unsigned MAX_STEPS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pce_pkg::in_word_t in_word,
  input  wire pce_pkg::cmd_t     cmd,
  output pce_pkg::sts_t          sts,
  output pce_pkg::out_word_t     out_word
);
  import pce_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_STEPS);
  localparam int unsigned IDN  = $clog2(MAX_STEPS + 2);
  localparam int unsigned CW   = (IDN > ID_W) ? IDN : ID_W;
  localparam logic [CW-1:0] GOAL_ID  = CW'(MAX_STEPS + 1);
  localparam logic [CW-1:0] LAST_ID  = CW'(MAX_STEPS);
  localparam logic [AW-1:0] LAST_ROW = AW'(MAX_STEPS - 1);

  kind_t                kind_r;
  logic [CW-1:0]        a_r, b_r;
  logic [MAX_STEPS-1:0] row_a_r, row_b_r;
  logic [AW-1:0]        k_r;
  logic                 pend_r;
  logic [AW-1:0]        pend_addr_r;
  logic [MAX_STEPS-1:0] vld_r;
  logic                 rd_vld_r;
  out_word_t            out_word_r;

  logic [CW-1:0]        a_m1, b_m1;
  logic [AW-1:0]        a_idx, b_idx, rd_addr;
  logic [MAX_STEPS-1:0] rd_data, rd_row, gain, wr_data;
  logic                 walk_rd, hit;
  logic                 invalid, a_plan, b_plan, same;
  logic                 bit_ab, bit_ba;
  status_t              add_status;
  out_word_t            res;

  assign a_m1  = a_r - 1'b1;
  assign b_m1  = b_r - 1'b1;
  assign a_idx = a_m1[AW-1:0];
  assign b_idx = b_m1[AW-1:0];

  assign walk_rd = cmd.rd_en && (cmd.rd_sel == RD_WALK);

  always_comb begin
    case (cmd.rd_sel)
      RD_FIRST:  rd_addr = a_idx;
      RD_SECOND: rd_addr = b_idx;
      default:   rd_addr = k_r;
    endcase
  end

  // rows never written read as empty
  assign rd_row  = rd_vld_r ? rd_data : '0;
  assign gain    = row_b_r | (MAX_STEPS'(1) << b_idx);
  assign wr_data = rd_row | gain;
  assign hit     = pend_r && ((pend_addr_r == a_idx) || rd_row[a_idx]);

  pce_ram #(
    .WIDTH (MAX_STEPS),
    .DEPTH (MAX_STEPS)
  ) u_rows (
    .clk     (clk),
    .wr_en   (hit),
    .wr_addr (pend_addr_r),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= walk_rd;
      if (hit) begin
        vld_r[pend_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_word.kind;
      a_r    <= CW'(in_word.first_step);
      b_r    <= CW'(in_word.second_step);
      k_r    <= '0;
    end else if (walk_rd) begin
      k_r <= k_r + 1'b1;
    end
    if (cmd.rd_en) begin
      rd_vld_r <= vld_r[rd_addr];
    end
    pend_addr_r <= k_r;
    if (cmd.cap_a) begin
      row_a_r <= rd_row;
    end
    if (cmd.cap_b) begin
      row_b_r <= rd_row;
    end
    if (cmd.res_load) begin
      out_word_r <= res;
    end
  end

  assign invalid = (a_r > GOAL_ID) || (b_r > GOAL_ID);
  assign a_plan  = (a_r != '0) && (a_r <= LAST_ID);
  assign b_plan  = (b_r != '0) && (b_r <= LAST_ID);
  assign same    = (a_r == b_r);
  assign bit_ab  = a_plan && b_plan && !same && row_a_r[b_idx];
  assign bit_ba  = a_plan && b_plan && !same && row_b_r[a_idx];

  always_comb begin
    if (invalid) begin
      add_status = ST_INVALID;
    end else if (same) begin
      add_status = ST_CONFLICT;
    end else if ((a_r == '0) || (b_r == GOAL_ID)) begin
      add_status = ST_BOUNDARY;
    end else if ((a_r == GOAL_ID) || (b_r == '0)) begin
      add_status = ST_CONFLICT;
    end else if (bit_ba) begin
      add_status = ST_CONFLICT;
    end else if (bit_ab) begin
      add_status = ST_IMPLIED;
    end else begin
      add_status = ST_OK;
    end
  end

  always_comb begin
    res = '0;
    res.status = ST_OK;
    if (invalid) begin
      res.status = ST_INVALID;
    end else if (kind_r == KIND_ADD) begin
      res.status = add_status;
    end else begin
      res.ordered_before = bit_ab;
      res.may_overlap    = a_plan && b_plan && !same && !bit_ab && !bit_ba;
      if (same) begin
        res.may_precede = 1'b0;
        res.may_follow  = 1'b0;
      end else if ((a_r == '0) || (b_r == GOAL_ID)) begin
        res.may_precede = 1'b1;
        res.may_follow  = 1'b0;
      end else if ((a_r == GOAL_ID) || (b_r == '0)) begin
        res.may_precede = 1'b0;
        res.may_follow  = 1'b1;
      end else begin
        res.may_precede = !bit_ba;
        res.may_follow  = !bit_ab;
      end
    end
  end

  assign sts.add_go    = (kind_r == KIND_ADD) && (add_status == ST_OK);
  assign sts.walk_last = (k_r == LAST_ROW);
  assign out_word      = out_word_r;

endmodule
`default_nettype wire

// File: rtl/core/precedence_closure_engine_core.sv
// precedence closure engine: a transitively closed "runs before" relation over
// plan steps 1..MAX_STEPS, one matrix row per step in a single row ram
// input word: kind (add ordering / query pair), first_step, second_step;
// step 0 is the initial step and MAX_STEPS+1 the goal step, both implicit
// output word: status plus ordered_before, may_precede, may_follow, may_overlap
// one output word per input word, in order
// a query or a rejected add reads the first and second rows, checks the pair and
// loads the result; a stored add also walks the rows, reading every row through
// the one ram read port and rewriting those that reach the first step
// the next word can be taken in the cycle after the result is loaded; the engine
// does not take a new word while it is still busy with the last one
// only one word is in flight: in_ready is high while the engine is idle, also
// while a finished word still waits in the output register
// if the receiver stalls, the output register holds its word; the next item is
// processed and then waits until that word has been taken
// reset clears the relation at once through per-row valid bits, and empties the
// output register; no clearing pass is needed
`default_nettype none
module precedence_closure_engine_core #(
  parameter int unsigned MAX_STEPS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pce_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pce_pkg::out_word_t      out_word
);
  import pce_pkg::*;

  // command and status between sequencer and row datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: read first row, read second row, check, optional walk, result
  pce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // row ram, valid bits, pair checks, closure update and output register
  pce_dp #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule
`default_nettype wire
